>>> rtl/core/svd_pkg.sv
`timescale 1ns / 1ps

package svd_pkg;

    localparam int DATA_W    = 8;
    localparam int MAG_W     = 62;
    localparam int NUM_W     = 63;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;

    // First byte carries six magnitude bits; every later byte carries seven.
    localparam int FIRST_BITS = 6;
    localparam int GROUP_BITS = 7;

    // Largest bit position at which a continuation byte is still taken.
    localparam int MAX_SHIFT = 55;

    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(FIRST_BITS);
    localparam logic [POS_W-1:0] POS_STEP  = POS_W'(GROUP_BITS);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SHIFT);

    localparam int CONT_BIT = 7;
    localparam int SIGN_BIT = 6;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_TOO_LONG   = 2'd1,
        STATUS_END_IN_NUM = 2'd2
    } status_t;

endpackage

>>> rtl/core/signed_varint_stream_decoder.sv
`timescale 1ns / 1ps

// A byte that completes a number or raises an error shows its result on m_*
// in the cycle after the input transaction; other bytes give no result.
// Throughput: one byte per cycle, limited only by the single result register
// (s_ready is high whenever that register is empty or being drained).
// Reset (aresetn low, synchronous): decoder state returns to awaiting the first
// byte of a number, discarding is cleared and no result is held.
module signed_varint_stream_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [svd_pkg::DATA_W-1:0]          s_data_byte,
    input  logic                                s_record_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [svd_pkg::NUM_W-1:0]    m_number,
    output logic [svd_pkg::STATUS_W-1:0]        m_status
);

    logic [svd_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [svd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        neg_reg, neg_next;
    logic                        in_num_reg, in_num_next;
    logic                        discard_reg, discard_next;

    logic                        out_valid_reg, out_valid_next;
    logic [svd_pkg::NUM_W-1:0]   out_number_reg, out_number_next;
    svd_pkg::status_t            out_status_reg, out_status_next;

    logic                        s_fire;
    logic                        emit;
    logic [svd_pkg::MAG_W-1:0]   mag_work;
    logic                        neg_work;
    logic [svd_pkg::MAG_W-1:0]   group_shifted;

    assign s_ready = !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign group_shifted = {{(svd_pkg::MAG_W - svd_pkg::GROUP_BITS){1'b0}},
                            s_data_byte[svd_pkg::GROUP_BITS-1:0]} << pos_reg;

    always_comb begin
        mag_next        = mag_reg;
        pos_next        = pos_reg;
        neg_next        = neg_reg;
        in_num_next     = in_num_reg;
        discard_next    = discard_reg;
        emit            = 1'b0;
        out_number_next = out_number_reg;
        out_status_next = out_status_reg;
        mag_work        = mag_reg;
        neg_work        = neg_reg;

        if (s_fire) begin
            if (discard_reg) begin
                if (s_record_last) begin
                    discard_next = 1'b0;
                end
            end else if (in_num_reg && (pos_reg > svd_pkg::POS_LIMIT)) begin
                // A tenth byte: the number is abandoned and the rest of the
                // record is skipped unless this byte already ends it.
                emit            = 1'b1;
                out_number_next = '0;
                out_status_next = svd_pkg::STATUS_TOO_LONG;
                discard_next    = !s_record_last;
            end else begin
                if (!in_num_reg) begin
                    mag_work = {{(svd_pkg::MAG_W - svd_pkg::FIRST_BITS){1'b0}},
                                s_data_byte[svd_pkg::FIRST_BITS-1:0]};
                    neg_work = s_data_byte[svd_pkg::SIGN_BIT];
                    pos_next = svd_pkg::FIRST_POS;
                end else begin
                    // Groups never overlap, so the add reduces to an OR.
                    mag_work = mag_reg | group_shifted;
                    pos_next = pos_reg + svd_pkg::POS_STEP;
                end
                mag_next    = mag_work;
                neg_next    = neg_work;
                in_num_next = 1'b1;

                if (s_data_byte[svd_pkg::CONT_BIT]) begin
                    if (s_record_last) begin
                        emit            = 1'b1;
                        out_number_next = '0;
                        out_status_next = svd_pkg::STATUS_END_IN_NUM;
                    end
                end else begin
                    emit            = 1'b1;
                    out_status_next = svd_pkg::STATUS_OK;
                    out_number_next = neg_work ? (svd_pkg::NUM_W'(0) - {1'b0, mag_work})
                                               : {1'b0, mag_work};
                end
            end

            if (emit) begin
                mag_next    = '0;
                pos_next    = svd_pkg::FIRST_POS;
                neg_next    = 1'b0;
                in_num_next = 1'b0;
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg       <= '0;
            pos_reg       <= svd_pkg::FIRST_POS;
            neg_reg       <= 1'b0;
            in_num_reg    <= 1'b0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mag_reg       <= mag_next;
            pos_reg       <= pos_next;
            neg_reg       <= neg_next;
            in_num_reg    <= in_num_next;
            discard_reg   <= discard_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_number_reg <= out_number_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_number = out_number_reg;
    assign m_status = out_status_reg;

endmodule

>>> rtl/core/svd_checker.sv
`timescale 1ns / 1ps

module svd_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_ready,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [svd_pkg::NUM_W-1:0]    m_number,
    input  logic [svd_pkg::STATUS_W-1:0]        m_status
);

    // A result that is not taken stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped while stalled");

    // Error results always carry a zero number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != svd_pkg::STATUS_OK) |-> (m_number == '0))
        else $error("error result with nonzero number");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the result register empty, the input side must be open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no pending result");

endmodule

bind signed_varint_stream_decoder svd_checker u_svd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_number (m_number),
    .m_status (m_status)
);

>>> bench/varint_decode_checker.sv
`timescale 1ns / 1ps

module varint_decode_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [svd_pkg::DATA_W-1:0]          s_data_byte,
    input  logic                                s_record_last,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [svd_pkg::NUM_W-1:0]    m_number,
    input  logic [svd_pkg::STATUS_W-1:0]        m_status,
    output int                                  mismatches,
    output int                                  outstanding
);

    typedef struct packed {
        logic [svd_pkg::NUM_W-1:0] number;
        svd_pkg::status_t          status;
    } decoded_t;

    decoded_t expected_numbers[$];
    decoded_t wanted;
    decoded_t predicted;

    logic [svd_pkg::MAG_W-1:0] magnitude;
    logic [svd_pkg::POS_W-1:0] next_pos;
    logic                      negative;
    logic                      inside_number;
    logic                      skipping;

    function automatic void restart_number();
        magnitude     = '0;
        next_pos      = svd_pkg::FIRST_POS;
        negative      = 1'b0;
        inside_number = 1'b0;
    endfunction

    // Advances the decoder by one byte; returns 1 when the byte produces a result.
    function automatic logic decode_byte(input logic [svd_pkg::DATA_W-1:0] b,
                                         input logic last,
                                         output decoded_t result);
        logic [svd_pkg::NUM_W-1:0] value;
        result.number = '0;
        result.status = svd_pkg::STATUS_OK;
        if (skipping) begin
            if (last) skipping = 1'b0;
            return 1'b0;
        end
        if (!inside_number) begin
            magnitude     = svd_pkg::MAG_W'(b[svd_pkg::FIRST_BITS-1:0]);
            negative      = b[svd_pkg::SIGN_BIT];
            next_pos      = svd_pkg::FIRST_POS;
            inside_number = 1'b1;
        end else begin
            // Nine bytes already fill all 62 magnitude bits, so a tenth is refused.
            if (next_pos > svd_pkg::POS_LIMIT) begin
                skipping = !last;
                restart_number();
                result.status = svd_pkg::STATUS_TOO_LONG;
                return 1'b1;
            end
            magnitude = magnitude
                      + (svd_pkg::MAG_W'(b[svd_pkg::GROUP_BITS-1:0]) << next_pos);
            next_pos  = next_pos + svd_pkg::POS_STEP;
        end
        if (b[svd_pkg::CONT_BIT]) begin
            if (!last) return 1'b0;
            restart_number();
            result.status = svd_pkg::STATUS_END_IN_NUM;
            return 1'b1;
        end
        value = {1'b0, magnitude};
        result.number = negative ? -value : value;
        restart_number();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_numbers.delete();
            restart_number();
            skipping = 1'b0;
        end else begin
            // A result never leaves in the cycle its byte arrives, so drain first.
            if (m_valid && m_ready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch($sformatf("result %0d status %0d with none expected",
                                              m_number, m_status));
                end else begin
                    wanted = expected_numbers.pop_front();
                    if (m_number !== wanted.number)
                        report_mismatch($sformatf("number %0d, expected %0d",
                                                  m_number, $signed(wanted.number)));
                    if (m_status !== wanted.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, wanted.status));
                end
            end
            if (s_valid && s_ready) begin
                if (decode_byte(s_data_byte, s_record_last, predicted))
                    expected_numbers = {expected_numbers, predicted};
            end
        end
        outstanding <= expected_numbers.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ITEMS_PER_PHASE = 550;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 5000;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [svd_pkg::DATA_W-1:0]       s_data_byte;
    logic                             s_record_last;
    logic                             m_valid;
    logic                             m_ready;
    logic signed [svd_pkg::NUM_W-1:0] m_number;
    logic [svd_pkg::STATUS_W-1:0]     m_status;

    int   mismatches;
    int   outstanding;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   bytes_sent;
    int   quiet_cycles;
    logic hold_request;

    always #5 aclk = ~aclk;

    signed_varint_stream_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_record_last (s_record_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_number      (m_number),
        .m_status      (m_status)
    );

    varint_decode_checker decode_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_record_last (s_record_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_number      (m_number),
        .m_status      (m_status),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Receiver: random back-pressure, plus one long hold-off when requested.
    initial begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [svd_pkg::DATA_W-1:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_record_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [svd_pkg::GROUP_BITS-1:0] random_group();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '1;
        if (pick == 1) return '0;
        return svd_pkg::GROUP_BITS'($urandom);
    endfunction

    function automatic int pick_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return $urandom_range(1, 2);
        if (pick < 85) return $urandom_range(3, 6);
        return $urandom_range(7, 9);
    endfunction

    task automatic send_number(input int len, input logic cont_at_end, input logic last);
        logic [svd_pkg::DATA_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            b[svd_pkg::GROUP_BITS-1:0] = random_group();
            b[svd_pkg::CONT_BIT]       = (i == len - 1) ? cont_at_end : 1'b1;
            send_byte(b, last && (i == len - 1));
        end
    endtask

    task automatic send_record();
        int   kind;
        int   count;
        logic tail;
        kind  = $urandom_range(0, 99);
        count = $urandom_range(0, 3);
        tail  = 1'($urandom_range(0, 1));
        if (kind < 70) begin
            for (int i = 0; i <= count; i++)
                send_number(pick_length(), 1'b0, i == count);
        end else if (kind < 80) begin
            // The record ends while its final number still expects more bytes.
            repeat (count) send_number(pick_length(), 1'b0, 1'b0);
            send_number($urandom_range(1, 9), 1'b1, 1'b1);
        end else if (kind < 92) begin
            // Everything after the tenth byte is dropped up to the record end.
            repeat (count) send_number(pick_length(), 1'b0, 1'b0);
            send_number($urandom_range(10, 12), 1'($urandom_range(0, 1)), !tail);
            if (tail) send_number(pick_length(), 1'b0, 1'b1);
        end else begin
            repeat ($urandom_range(1, 6))
                send_byte(svd_pkg::DATA_W'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_record_last = 1'b0;
        hold_request  = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 60;
        bytes_sent    = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_byte(8'h00, 1'b0);
        send_byte(8'h3F, 1'b0);
        // Sign set with zero magnitude still decodes to zero.
        send_byte(8'h40, 1'b0);
        // Most negative value: sign set and all 62 magnitude bits set.
        send_byte(8'hFF, 1'b0);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'hC0, 1'b0);
        repeat (8) send_byte(8'h80, 1'b0);
        send_byte(8'h2A, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Stall the result side while results keep coming, so the input backs up.
        hold_request = 1'b1;
        send_byte(8'hBF, 1'b0);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        repeat (20) send_byte({1'b0, 7'($urandom)}, 1'($urandom_range(0, 1)));

        while (bytes_sent < ITEMS_PER_PHASE) send_record();
        send_idle_pct = 60;
        recv_idle_pct = 15;
        while (bytes_sent < 2 * ITEMS_PER_PHASE) send_record();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_sent < 3 * ITEMS_PER_PHASE) send_record();
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> signed_varint_stream_decoder.f
rtl/core/svd_pkg.sv
rtl/core/signed_varint_stream_decoder.sv
rtl/core/svd_checker.sv
bench/varint_decode_checker.sv
bench/testbench.sv
